### rtl/tpeq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the timestamped press event queue
package tpeq_pkg;

    localparam int TICK_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] KIND_RESET = 3'd0;
    localparam logic [2:0] KIND_BEGIN = 3'd1;
    localparam logic [2:0] KIND_PAD   = 3'd2;
    localparam logic [2:0] KIND_TOUCH = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;
    localparam logic [2:0] KIND_STEP  = 3'd5;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_DISCARD = 2'd1;
    localparam logic [1:0] MODE_PAUSED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_THR = 1'd1;

    localparam logic [31:0]        JUMP_MASK_RESET = 32'd0;
    localparam logic signed [15:0] STICK_THR_RESET = 16'sd41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DRAIN
    } tpeq_state_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic              src;
        logic              level;
    } tpeq_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } tpeq_qcmd_t;

endpackage

### rtl/tpeq_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces
interface tpeq_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                kind;
    logic [1:0]                poll_sel;
    logic [tpeq_pkg::TICK_W-1:0] tick;
    logic [31:0]               held_buttons;
    logic signed [15:0]        stick_y;
    logic                      touching;
    logic                      touch_blocked;

    modport source (
        output valid, kind, poll_sel, tick, held_buttons, stick_y, touching, touch_blocked,
        input  ready
    );
    modport sink (
        input  valid, kind, poll_sel, tick, held_buttons, stick_y, touching, touch_blocked,
        output ready
    );
endinterface

interface tpeq_out_if;
    logic valid;
    logic ready;
    logic pressed_jump;
    logic hold_jump;
    logic prev_pressed_jump;
    logic prev_hold_jump;

    modport source (
        output valid, pressed_jump, hold_jump, prev_pressed_jump, prev_hold_jump,
        input  ready
    );
    modport sink (
        input  valid, pressed_jump, hold_jump, prev_pressed_jump, prev_hold_jump,
        output ready
    );
endinterface

### rtl/tpeq_mem.sv
`timescale 1ns / 1ps
// event storage, one write port and one registered read port
module tpeq_mem #(
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  tpeq_pkg::tpeq_entry_t wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output tpeq_pkg::tpeq_entry_t rd_data
);

    tpeq_pkg::tpeq_entry_t mem [DEPTH];
    tpeq_pkg::tpeq_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tpeq_queue.sv
`timescale 1ns / 1ps
// circular event queue with drop-oldest on overflow
module tpeq_queue #(
    parameter int DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tpeq_pkg::tpeq_qcmd_t  cmd,
    input  tpeq_pkg::tpeq_entry_t push_entry,
    output logic                  empty,
    output tpeq_pkg::tpeq_entry_t front_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;
    logic             mem_we;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        front_next = front_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        if (cmd.clear)
        begin
            front_next = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            mem_we    = 1'b1;
            tail_next = ptr_inc(tail_reg);
            if (full)
            begin
                // drop oldest
                front_next = ptr_inc(front_reg);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            front_next = ptr_inc(front_reg);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    tpeq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (tail_reg),
        .wr_data (push_entry),
        .rd_addr (front_next),
        .rd_data (front_entry)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_ptr_align: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> front_reg == tail_reg)
        else $error("queue pointers disagree with count");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0)
        else $error("pop on empty queue");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && !cmd.push && !cmd.clear) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not lower count");
`endif

endmodule

### rtl/timestamped_press_event_queue.sv
`timescale 1ns / 1ps
// top level: level tracking, poll modes, step drain and result register
//
//  channel   dir  handshake     payload
//  item      in   valid/ready   kind, poll_sel, tick, held_buttons, stick_y, touching,
//                               touch_blocked
//  result    out  valid/ready   pressed_jump, hold_jump, prev_pressed_jump, prev_hold_jump
//  wr_*      in   wr_en         wr_index, wr_data
//
// a step drains queued events one event per cycle through the queue memory read port.
// a step whose result finds the output register still full waits until it is taken.
// rst_n clears control state and the queue pointers; the queue memory itself is not cleared.
// the next request is taken while a result waits in the output register.
module timestamped_press_event_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tpeq_in_if.sink                             item,
    tpeq_out_if.source                          result,
    input  logic                                wr_en,
    input  logic [tpeq_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [tpeq_pkg::CFG_DATA_W-1:0]     wr_data
);

    tpeq_pkg::tpeq_state_t state_reg, state_next;

    logic [31:0]        jump_mask_reg;
    logic signed [15:0] stick_thr_reg;

    logic [1:0] raw_reg, raw_next;
    logic [1:0] mask_reg, mask_next;
    logic [1:0] eff_reg, eff_next;
    logic [1:0] step_reg, step_next;
    logic [1:0] prev_result_reg, prev_result_next;
    logic       ready_reg, ready_next;
    logic [1:0] mode_reg, mode_next;
    logic       pressed_acc_reg, pressed_acc_next;
    logic       out_valid_reg, out_valid_next;

    logic [tpeq_pkg::TICK_W-1:0] window_reg, window_next;
    logic pressed_out_reg, pressed_out_next;
    logic hold_out_reg, hold_out_next;
    logic prev_pressed_out_reg, prev_pressed_out_next;
    logic prev_hold_out_reg, prev_hold_out_next;

    logic item_ready;
    logic drain_pop;
    logic result_load;
    logic in_fire;
    logic hit;
    logic pad_raw;
    logic touch_held;
    logic src_sel;
    logic raw_s;
    logic eff_s;
    logic hold_val;

    tpeq_pkg::tpeq_qcmd_t  q_cmd;
    tpeq_pkg::tpeq_entry_t push_entry;
    tpeq_pkg::tpeq_entry_t front_entry;
    logic                  q_empty;

    assign in_fire    = item.valid & item_ready;
    assign hit        = !q_empty && (front_entry.tick <= window_reg);
    assign pad_raw    = ((item.held_buttons & jump_mask_reg) != 32'd0)
                        || (item.stick_y >= stick_thr_reg);
    assign touch_held = item.touching & ~item.touch_blocked;
    assign src_sel    = (item.kind == tpeq_pkg::KIND_TOUCH);
    assign raw_s      = src_sel ? touch_held : pad_raw;
    assign eff_s      = raw_s & ~mask_reg[src_sel];
    assign hold_val   = pressed_acc_reg | (|step_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpeq_pkg::ST_IDLE:
            begin
                if (in_fire && item.kind == tpeq_pkg::KIND_STEP)
                begin
                    state_next = tpeq_pkg::ST_FETCH;
                end
            end
            tpeq_pkg::ST_FETCH:
            begin
                state_next = tpeq_pkg::ST_DRAIN;
            end
            tpeq_pkg::ST_DRAIN:
            begin
                if (result_load)
                begin
                    state_next = tpeq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpeq_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_ready  = 1'b0;
        drain_pop   = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            tpeq_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            tpeq_pkg::ST_FETCH:
            begin
                item_ready = 1'b0;
            end
            tpeq_pkg::ST_DRAIN:
            begin
                if (hit)
                begin
                    drain_pop = 1'b1;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    result_load = 1'b1;
                end
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // level tracking and queue commands
    always_comb
    begin
        raw_next              = raw_reg;
        mask_next             = mask_reg;
        eff_next              = eff_reg;
        step_next             = step_reg;
        ready_next            = ready_reg;
        mode_next             = mode_reg;
        prev_result_next      = prev_result_reg;
        pressed_acc_next      = pressed_acc_reg;
        window_next           = window_reg;
        pressed_out_next      = pressed_out_reg;
        hold_out_next         = hold_out_reg;
        prev_pressed_out_next = prev_pressed_out_reg;
        prev_hold_out_next    = prev_hold_out_reg;
        q_cmd                 = '0;
        push_entry.tick       = item.tick;
        push_entry.src        = src_sel;
        push_entry.level      = eff_s;

        if (in_fire)
        begin
            case (item.kind) inside
                tpeq_pkg::KIND_RESET:
                begin
                    q_cmd.clear = 1'b1;
                    raw_next    = '0;
                    mask_next   = '0;
                    eff_next    = '0;
                    step_next   = '0;
                    ready_next  = 1'b0;
                    mode_next   = tpeq_pkg::MODE_DISCARD;
                end
                tpeq_pkg::KIND_BEGIN:
                begin
                    mode_next = item.poll_sel;
                    if (item.poll_sel == tpeq_pkg::MODE_NORMAL && !ready_reg)
                    begin
                        step_next = eff_reg;
                    end
                end
                tpeq_pkg::KIND_PAD, tpeq_pkg::KIND_TOUCH:
                begin
                    raw_next[src_sel] = raw_s;
                    if (!raw_s)
                    begin
                        mask_next[src_sel] = 1'b0;
                    end
                    if (eff_s != eff_reg[src_sel])
                    begin
                        eff_next[src_sel] = eff_s;
                        q_cmd.push        = (mode_reg == tpeq_pkg::MODE_NORMAL);
                    end
                end
                tpeq_pkg::KIND_END:
                begin
                    if (mode_reg == tpeq_pkg::MODE_NORMAL)
                    begin
                        ready_next = 1'b1;
                    end
                    else
                    begin
                        q_cmd.clear = 1'b1;
                        ready_next  = 1'b0;
                        if (mode_reg == tpeq_pkg::MODE_PAUSED)
                        begin
                            mask_next = raw_reg;
                            eff_next  = '0;
                        end
                    end
                end
                tpeq_pkg::KIND_STEP:
                begin
                    window_next      = item.tick;
                    pressed_acc_next = 1'b0;
                end
                default:
                begin
                    q_cmd = '0;
                end
            endcase
        end

        if (drain_pop)
        begin
            q_cmd.pop                   = 1'b1;
            step_next[front_entry.src]  = front_entry.level;
            if (front_entry.level && !step_reg[front_entry.src])
            begin
                pressed_acc_next = 1'b1;
            end
        end

        if (result_load)
        begin
            pressed_out_next      = pressed_acc_reg;
            hold_out_next         = hold_val;
            prev_pressed_out_next = prev_result_reg[0];
            prev_hold_out_next    = prev_result_reg[1];
            prev_result_next      = {hold_val, pressed_acc_reg};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tpeq_pkg::ST_IDLE;
            raw_reg         <= '0;
            mask_reg        <= '0;
            eff_reg         <= '0;
            step_reg        <= '0;
            ready_reg       <= 1'b0;
            mode_reg        <= tpeq_pkg::MODE_DISCARD;
            prev_result_reg <= '0;
            pressed_acc_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            raw_reg         <= raw_next;
            mask_reg        <= mask_next;
            eff_reg         <= eff_next;
            step_reg        <= step_next;
            ready_reg       <= ready_next;
            mode_reg        <= mode_next;
            prev_result_reg <= prev_result_next;
            pressed_acc_reg <= pressed_acc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg           <= window_next;
        pressed_out_reg      <= pressed_out_next;
        hold_out_reg         <= hold_out_next;
        prev_pressed_out_reg <= prev_pressed_out_next;
        prev_hold_out_reg    <= prev_hold_out_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_mask_reg <= tpeq_pkg::JUMP_MASK_RESET;
            stick_thr_reg <= tpeq_pkg::STICK_THR_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tpeq_pkg::CFG_JUMP_MASK: jump_mask_reg <= wr_data;
                tpeq_pkg::CFG_STICK_THR: stick_thr_reg <= $signed(wr_data[15:0]);
                default:                 jump_mask_reg <= jump_mask_reg;
            endcase
        end
    end

    tpeq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (q_cmd),
        .push_entry  (push_entry),
        .empty       (q_empty),
        .front_entry (front_entry)
    );

    assign item.ready               = item_ready;
    assign result.valid             = out_valid_reg;
    assign result.pressed_jump      = pressed_out_reg;
    assign result.hold_jump         = hold_out_reg;
    assign result.prev_pressed_jump = prev_pressed_out_reg;
    assign result.prev_hold_jump    = prev_hold_out_reg;

`ifndef SYNTHESIS
    a_pop_only_drain: assert property (@(posedge clk) disable iff (!rst_n)
        q_cmd.pop |-> (state_reg == tpeq_pkg::ST_DRAIN && !q_cmd.push && !q_cmd.clear))
        else $error("queue pop outside drain");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> out_valid_reg)
        else $error("result load lost");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> (!out_valid_reg || result.ready))
        else $error("result overwritten before taken");
`endif

endmodule
